>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the trilinear field lookup.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_PROP(lbl, clk, rstn, !(cond), msg)
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> sv/fmtl_pkg.sv
// Types, codes and constants of the trilinear field lookup.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package fmtl_pkg;

  localparam int unsigned GRID_X_DEF = 16;
  localparam int unsigned GRID_Y_DEF = 16;
  localparam int unsigned GRID_Z_DEF = 16;

  localparam int unsigned COMP_W    = 24;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned WGT_W     = 17;
  localparam int unsigned IDX_MAX_W = 8;
  localparam int unsigned GIDX_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CORNERS   = 8;
  localparam int unsigned S_TDATA_W = 184;
  localparam int unsigned M_TDATA_W = 72;

  localparam logic [WGT_W-1:0]   WGT_ONE     = WGT_W'(65536);
  localparam logic [COORD_W-1:0] INV_SP_RST  = COORD_W'(65536);

  typedef logic [2:0][COMP_W-1:0]  vec_t;     // [0] x, [1] y, [2] z
  typedef logic [2:0][COORD_W-1:0] axis3_t;   // [0] x, [1] y, [2] z

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORG_X = 3'd0,
    CFG_ORG_Y = 3'd1,
    CFG_ORG_Z = 3'd2,
    CFG_INV_X = 3'd3,
    CFG_INV_Y = 3'd4,
    CFG_INV_Z = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_e;

  // Blend steps: four z lerps, two y lerps, one x lerp.
  typedef enum logic [2:0] {
    STEP_Z00 = 3'd0,
    STEP_Z01 = 3'd1,
    STEP_Z10 = 3'd2,
    STEP_Z11 = 3'd3,
    STEP_Y0  = 3'd4,
    STEP_Y1  = 3'd5,
    STEP_R   = 3'd6
  } blend_step_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOCATE,
    ST_READ,
    ST_BLEND,
    ST_DONE
  } fmtl_state_e;

  typedef struct packed {
    logic             outside;
    logic [WGT_W-1:0] wx;
    logic [WGT_W-1:0] wy;
    logic [WGT_W-1:0] wz;
  } loc_res_t;

  typedef struct packed {
    logic             valid;
    blend_step_e      step;
    logic [WGT_W-1:0] w;
  } bl_req_t;

  typedef struct packed {
    logic        valid;
    blend_step_e step;
  } bl_rsp_t;

endpackage

>>> sv/fmtl_store.sv
// Grid vector store: one write port, one registered read port.
// Sweeps itself to zero after reset. Depends on fmtl_pkg.
`timescale 1ns / 1ps
module fmtl_store import fmtl_pkg::*; #(
  parameter int unsigned ADDR_W = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  vec_t              wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output vec_t              rdata_o,
  output logic              busy_o
);

  vec_t              mem_q [2**ADDR_W];
  vec_t              rdata_q;
  logic              clr_busy_q;
  logic [ADDR_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + ADDR_W'(1);
      if (&clr_addr_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= '0;
    end else if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

endmodule

>>> sv/fmtl_locate.sv
// Maps a position to cell index and weight per axis with one shared
// 32x32 multiplier, one axis per cycle. Depends on fmtl_pkg.
`timescale 1ns / 1ps
module fmtl_locate import fmtl_pkg::*; #(
  parameter int unsigned GRID_X = GRID_X_DEF,
  parameter int unsigned GRID_Y = GRID_Y_DEF,
  parameter int unsigned GRID_Z = GRID_Z_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  axis3_t                      pos_i,
  input  axis3_t                      org_i,
  input  axis3_t                      inv_i,
  output logic                        done_o,
  output loc_res_t                    res_o,
  output logic [$clog2(GRID_X)-1:0]   idx_x_o,
  output logic [$clog2(GRID_Y)-1:0]   idx_y_o,
  output logic [$clog2(GRID_Z)-1:0]   idx_z_o
);

  localparam int unsigned IWX = $clog2(GRID_X);
  localparam int unsigned IWY = $clog2(GRID_Y);
  localparam int unsigned IWZ = $clog2(GRID_Z);
  localparam logic [COORD_W-1:0] LIM_X = COORD_W'(GRID_X - 1);
  localparam logic [COORD_W-1:0] LIM_Y = COORD_W'(GRID_Y - 1);
  localparam logic [COORD_W-1:0] LIM_Z = COORD_W'(GRID_Z - 1);

  logic                   run_q;
  logic [1:0]             cnt_q;
  logic                   v1_q, v2_q, done_q;
  axis_e                  ax1_q, ax2_q;
  logic [COORD_W:0]       d1_q;
  logic                   neg2_q;
  logic [2*COORD_W-1:0]   p2_q;
  logic                   out_q;
  logic [WGT_W-1:0]       wx_q, wy_q, wz_q;
  logic [IWX-1:0]         ix_q;
  logic [IWY-1:0]         iy_q;
  logic [IWZ-1:0]         iz_q;

  logic [COORD_W-1:0]     lim, hi, lo;
  logic                   out_ax, clamp;
  logic [IDX_MAX_W-1:0]   lo_idx;
  logic [WGT_W-1:0]       wgt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= AX_X;
      end else if (run_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == AX_Z) begin
          run_q <= 1'b0;
        end
      end
      v1_q   <= run_q;
      v2_q   <= v1_q;
      done_q <= v2_q && (ax2_q == AX_Z);
    end
  end

  // stage 1: offset from origin, stage 2: scale to grid units
  always_ff @(posedge clk_i) begin
    ax1_q  <= axis_e'(cnt_q);
    d1_q   <= {pos_i[cnt_q][COORD_W-1], pos_i[cnt_q]}
            - {org_i[cnt_q][COORD_W-1], org_i[cnt_q]};
    ax2_q  <= ax1_q;
    neg2_q <= d1_q[COORD_W];
    p2_q   <= (2*COORD_W)'(d1_q[COORD_W-1:0]) * (2*COORD_W)'(inv_i[ax1_q]);
  end

  always_comb begin
    unique case (ax2_q)
      AX_X:    lim = LIM_X;
      AX_Y:    lim = LIM_Y;
      AX_Z:    lim = LIM_Z;
      default: lim = LIM_X;
    endcase
    hi     = p2_q[2*COORD_W-1:COORD_W];
    lo     = p2_q[COORD_W-1:0];
    out_ax = neg2_q || (hi > lim) || ((hi == lim) && (lo != '0));
    clamp  = (hi >= lim);
    lo_idx = clamp ? IDX_MAX_W'(lim - COORD_W'(1)) : hi[IDX_MAX_W-1:0];
    wgt    = clamp ? WGT_ONE : {1'b0, lo[COORD_W-1:COORD_W-16]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= 1'b0;
    end else if (start_i) begin
      out_q <= 1'b0;
    end else if (v2_q) begin
      out_q <= out_q | out_ax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      unique case (ax2_q)
        AX_X: begin
          ix_q <= lo_idx[IWX-1:0];
          wx_q <= wgt;
        end
        AX_Y: begin
          iy_q <= lo_idx[IWY-1:0];
          wy_q <= wgt;
        end
        AX_Z: begin
          iz_q <= lo_idx[IWZ-1:0];
          wz_q <= wgt;
        end
        default: begin
        end
      endcase
    end
  end

  assign done_o  = done_q;
  assign res_o   = '{outside: out_q, wx: wx_q, wy: wy_q, wz: wz_q};
  assign idx_x_o = ix_q;
  assign idx_y_o = iy_q;
  assign idx_z_o = iz_q;

endmodule

>>> sv/fmtl_blend.sv
// Three-lane linear blend a + ((b-a)*w + 0.5) >> 16, three stages deep.
// Words pass diff, product and result registers. Depends on fmtl_pkg.
`timescale 1ns / 1ps
module fmtl_blend import fmtl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  bl_req_t req_i,
  input  vec_t    a_i,
  input  vec_t    b_i,
  output bl_rsp_t rsp_o,
  output vec_t    res_o
);

  localparam int unsigned DIFF_W = COMP_W + 1;
  localparam int unsigned PROD_W = DIFF_W + WGT_W + 1;

  logic                     v1_q, v2_q, v3_q;
  blend_step_e              s1_q, s2_q, s3_q;
  logic signed [DIFF_W-1:0] diff1_q [3];
  logic [WGT_W-1:0]         w1_q;
  vec_t                     a1_q, a2_q, res_q;
  logic signed [PROD_W-1:0] prod2_q [3];

  logic signed [DIFF_W-1:0] diff_d [3];
  logic signed [PROD_W-1:0] prod_d [3];
  logic signed [PROD_W-1:0] rnd, shf;
  vec_t                     res_d;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      diff_d[l] = $signed({b_i[l][COMP_W-1], b_i[l]}) - $signed({a_i[l][COMP_W-1], a_i[l]});
      prod_d[l] = diff1_q[l] * $signed({1'b0, w1_q});
    end
  end

  always_comb begin
    rnd   = '0;
    shf   = '0;
    res_d = '0;
    for (int l = 0; l < 3; l++) begin
      rnd      = prod2_q[l] + PROD_W'(32768);
      shf      = rnd >>> 16;
      res_d[l] = a2_q[l] + shf[COMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q    <= req_i.step;
    w1_q    <= req_i.w;
    a1_q    <= a_i;
    diff1_q <= diff_d;
    s2_q    <= s1_q;
    a2_q    <= a1_q;
    prod2_q <= prod_d;
    s3_q    <= s2_q;
    res_q   <= res_d;
  end

  assign rsp_o = '{valid: v3_q, step: s3_q};
  assign res_o = res_q;

endmodule

>>> sv/field_map_trilinear_lookup_unit.sv
// Trilinear field lookup: write words fill the grid store, query words
// return the blended vector; query time is set by the 8 single-port store
// reads and the 7 passes through the shared blend unit, skipped when outside;
// a write returns nothing. Throughput: a write per cycle while idle and not
// clearing; a new query is taken only after the last one's output load.
// Reset: async active low, then the store clears all 2**AW entries, no input.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module field_map_trilinear_lookup_unit import fmtl_pkg::*; #(
  parameter int unsigned GRID_X = GRID_X_DEF,
  parameter int unsigned GRID_Y = GRID_Y_DEF,
  parameter int unsigned GRID_Z = GRID_Z_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // grid_i, grid_j, grid_k, load_bx, load_by, load_bz, pos_x, pos_y, pos_z
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tuser,   // op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // field_x, field_y, field_z
  output logic                 m_axis_tuser,   // outside
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [COORD_W-1:0]   cfg_data_i
);

  localparam int unsigned IWX = $clog2(GRID_X);
  localparam int unsigned IWY = $clog2(GRID_Y);
  localparam int unsigned IWZ = $clog2(GRID_Z);
  localparam int unsigned AW  = IWX + IWY + IWZ;
  localparam logic [2:0]  RD_LAST = 3'(CORNERS - 1);

  fmtl_state_e state_q, state_d;

  axis3_t org_q, inv_q, pos_q;

  logic           in_acc, is_query, wr_en, clr_busy;
  logic [IDX_MAX_W-1:0] gi8, gj8, gk8;
  logic [AW-1:0]  waddr, raddr;
  vec_t           wdata, rdata;

  logic           loc_done;
  loc_res_t       loc;
  logic [IWX-1:0] ix0, ix;
  logic [IWY-1:0] iy0, iy;
  logic [IWZ-1:0] iz0, iz;

  logic [2:0]     rd_cnt_q, rd_cnt_d;
  logic           mem_re;
  logic           rv_q;
  logic [2:0]     rc_q;
  vec_t           hold_q, zpend_q, ypend_q, fin_q;

  bl_req_t        bl_req;
  bl_rsp_t        bl_rsp;
  vec_t           bl_a, bl_b, bl_res;
  logic           rd_odd, res_pair, res_final, res_last;

  logic           m_valid_q, m_valid_d, m_load;
  vec_t           m_data_q;
  logic           m_user_q;

  function automatic logic res_pair_lo(bl_rsp_t r);
    return r.valid && ((r.step == STEP_Z00) || (r.step == STEP_Z10));
  endfunction

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q <= '0;
      inv_q <= {INV_SP_RST, INV_SP_RST, INV_SP_RST};
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_ORG_X: org_q[AX_X] <= cfg_data_i;
        CFG_ORG_Y: org_q[AX_Y] <= cfg_data_i;
        CFG_ORG_Z: org_q[AX_Z] <= cfg_data_i;
        CFG_INV_X: inv_q[AX_X] <= cfg_data_i;
        CFG_INV_Y: inv_q[AX_Y] <= cfg_data_i;
        CFG_INV_Z: inv_q[AX_Z] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input side
  assign s_axis_tready = (state_q == ST_IDLE) && !clr_busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_query      = (s_axis_tuser == OP_QUERY);

  assign gi8   = IDX_MAX_W'(s_axis_tdata[3:0]);
  assign gj8   = IDX_MAX_W'(s_axis_tdata[7:4]);
  assign gk8   = IDX_MAX_W'(s_axis_tdata[11:8]);
  assign wdata = s_axis_tdata[83:12];
  assign waddr = {gi8[IWX-1:0], gj8[IWY-1:0], gk8[IWZ-1:0]};
  assign wr_en = in_acc && !is_query
              && ({1'b0, gi8} < (IDX_MAX_W+1)'(GRID_X))
              && ({1'b0, gj8} < (IDX_MAX_W+1)'(GRID_Y))
              && ({1'b0, gk8} < (IDX_MAX_W+1)'(GRID_Z));

  always_ff @(posedge clk_i) begin
    if (in_acc && is_query) begin
      pos_q <= s_axis_tdata[179:84];
    end
  end

  fmtl_store #(
    .ADDR_W (AW)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (mem_re),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .busy_o  (clr_busy)
  );

  fmtl_locate #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_locate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && is_query),
    .pos_i   (pos_q),
    .org_i   (org_q),
    .inv_i   (inv_q),
    .done_o  (loc_done),
    .res_o   (loc),
    .idx_x_o (ix0),
    .idx_y_o (iy0),
    .idx_z_o (iz0)
  );

  // corner reads, corner bits {dx, dy, dz}
  assign ix    = ix0 + IWX'(rd_cnt_q[2]);
  assign iy    = iy0 + IWY'(rd_cnt_q[1]);
  assign iz    = iz0 + IWZ'(rd_cnt_q[0]);
  assign raddr = {ix, iy, iz};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= mem_re;
    end
  end

  always_ff @(posedge clk_i) begin
    rc_q <= rd_cnt_q;
    if (rv_q && !rc_q[0]) begin
      hold_q <= rdata;
    end
    if (res_pair_lo(bl_rsp)) begin
      zpend_q <= bl_res;
    end
    if (bl_rsp.valid && (bl_rsp.step == STEP_Y0)) begin
      ypend_q <= bl_res;
    end
    if (res_last) begin
      fin_q <= bl_res;
    end
  end

  // blend issue: read pairs land on odd cycles, z results on even ones
  assign rd_odd    = rv_q && rc_q[0];
  assign res_pair  = bl_rsp.valid && ((bl_rsp.step == STEP_Z01) || (bl_rsp.step == STEP_Z11));
  assign res_final = bl_rsp.valid && (bl_rsp.step == STEP_Y1);
  assign res_last  = bl_rsp.valid && (bl_rsp.step == STEP_R);

  always_comb begin
    bl_req = '{valid: 1'b0, step: STEP_Z00, w: loc.wz};
    bl_a   = hold_q;
    bl_b   = rdata;
    priority if (rd_odd) begin
      bl_req = '{valid: 1'b1, step: blend_step_e'({1'b0, rc_q[2:1]}), w: loc.wz};
    end else if (res_pair) begin
      bl_req = '{valid: 1'b1,
                 step: (bl_rsp.step == STEP_Z01) ? STEP_Y0 : STEP_Y1,
                 w: loc.wy};
      bl_a   = zpend_q;
      bl_b   = bl_res;
    end else if (res_final) begin
      bl_req = '{valid: 1'b1, step: STEP_R, w: loc.wx};
      bl_a   = ypend_q;
      bl_b   = bl_res;
    end
  end

  fmtl_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (bl_req),
    .a_i    (bl_a),
    .b_i    (bl_b),
    .rsp_o  (bl_rsp),
    .res_o  (bl_res)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_cnt_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    mem_re   = 1'b0;
    m_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          state_d = ST_LOCATE;
        end
      end
      ST_LOCATE: begin
        if (loc_done) begin
          state_d = loc.outside ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        mem_re   = 1'b1;
        rd_cnt_d = rd_cnt_q + 3'd1;
        if (rd_cnt_q == RD_LAST) begin
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (res_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_load  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  assign m_valid_d = m_load || (m_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_data_q <= loc.outside ? '0 : fin_q;
      m_user_q <= loc.outside;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `ASSERT_NEVER(a_blend_issue_clash, clk_i, rst_ni, rd_odd && (res_pair || res_final), "blend issue collision")
  `ASSERT_PROP(a_final_in_blend, clk_i, rst_ni, res_last |-> (state_q == ST_BLEND), "final blend outside blend phase")
  `ASSERT_NEVER(a_read_while_clear, clk_i, rst_ni, mem_re && clr_busy, "store read during clear sweep")

endmodule
